### rtl/zgr_pkg.sv
// ----------------------------------------------------------------------------
// zgr_pkg
// Shared types, constants and helpers for the depth-buffered, Gouraud-shaded
// triangle rasterizer.
// ----------------------------------------------------------------------------
package zgr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 256;
  localparam int DEF_SCREEN_HEIGHT = 256;

  // Signed edge values (and the doubled area) fit in this many bits.
  localparam int EDGE_W = 36;
  // Signed attribute numerators (sum of edge value times attribute).
  localparam int NUM_W  = 54;

  localparam logic [15:0] FAR_DEPTH = 16'hFFFF;
  localparam logic [7:0]  COLOR_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_READ_DATA,
    ST_BOX,
    ST_EDGE,
    ST_EDGE_DRAIN,
    ST_NORM,
    ST_ATTR,
    ST_ATTR_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } vertex_t;

  typedef struct packed {
    logic [23:0] color;
    logic [15:0] depth;
  } pixel_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quot;
    logic [EDGE_W-1:0]       rem;
  } div_res_t;

  // An interpolated attribute held as floor quotient and remainder of its
  // numerator over the magnitude of the doubled triangle area.
  typedef struct packed {
    logic signed [NUM_W-1:0] q;
    logic [EDGE_W-1:0]       r;
  } acc_t;

  // Adds a step that was itself split into quotient and remainder.
  function automatic acc_t acc_step(acc_t a, logic signed [NUM_W-1:0] dq,
                                    logic [EDGE_W-1:0] dr, logic [EDGE_W-1:0] den);
    logic [EDGE_W:0] s;
    acc_t            o;
    s = {1'b0, a.r} + {1'b0, dr};
    if (s >= {1'b0, den}) begin
      o.r = EDGE_W'(s - {1'b0, den});
      o.q = a.q + dq + NUM_W'(1);
    end else begin
      o.r = s[EDGE_W-1:0];
      o.q = a.q + dq;
    end
    return o;
  endfunction

endpackage

### rtl/zgr_frame_mem.sv
// ----------------------------------------------------------------------------
// zgr_frame_mem
// Pixel store holding colour and depth per pixel; one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module zgr_frame_mem #(
  parameter int DEPTH = zgr_pkg::DEF_SCREEN_WIDTH * zgr_pkg::DEF_SCREEN_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  zgr_pkg::pixel_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output zgr_pkg::pixel_t rd_data
);

  zgr_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/zgr_div.sv
// ----------------------------------------------------------------------------
// zgr_div
// Bit-serial floor divider: signed numerator over a positive divisor, giving
// the floor quotient and a remainder in the range zero to divisor minus one.
// ----------------------------------------------------------------------------
module zgr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [zgr_pkg::NUM_W-1:0] numer,
  input  logic [zgr_pkg::EDGE_W-1:0]      denom,
  output zgr_pkg::div_res_t               res
);

  localparam int NW    = zgr_pkg::NUM_W;
  localparam int EW    = zgr_pkg::EDGE_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    quo;
  logic [EW-1:0]    rem;
  logic [EW-1:0]    den;
  logic             neg;
  logic [EW:0]      trial;
  logic             trial_ge;

  assign trial    = {rem, quo[NW-1]};
  assign trial_ge = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      fin      <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
        neg  <= numer[NW-1];
        quo  <= numer[NW-1] ? NW'(-numer) : NW'(numer);
        rem  <= '0;
        den  <= denom;
      end else if (busy) begin
        quo <= {quo[NW-2:0], trial_ge};
        rem <= trial_ge ? EW'(trial - {1'b0, den}) : trial[EW-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        // Magnitude result turned into a floor result for negative numerators.
        res.done <= 1'b1;
        if (neg && (rem != '0)) begin
          res.quot <= ~quo;
          res.rem  <= den - rem;
        end else if (neg) begin
          res.quot <= NW'(-quo);
          res.rem  <= '0;
        end else begin
          res.quot <= quo;
          res.rem  <= rem;
        end
      end
    end
  end

endmodule

### rtl/zbuffer_gouraud_triangle_raster_unit.sv
// ----------------------------------------------------------------------------
// zbuffer_gouraud_triangle_raster_unit
// Triangle rasterizer with depth test and Gouraud shading over a pixel store.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat. A vertex beat is held until
// three have arrived; the third draws the triangle into the pixel store and
// its result carries the number of pixels written. A clear beat fills every
// pixel with its colour and the farthest depth, a read beat returns one
// pixel. After reset the block first runs a clearing pass that zeroes the
// store, one pixel per cycle, with in_ready held low until it ends; a clear
// beat fills the store in the same way. A triangle's setup time is set by the
// shared serial divider that splits each of twelve interpolation terms into a
// quotient and a remainder (one quotient bit per cycle); its walk of the
// screen-clamped bounding box is paced by the single read port of the pixel
// store: a covered pixel is read and, if nearer than the stored depth,
// written back in the next cycle. Within one triangle no pixel is visited
// twice, so the read of one pixel never meets the write-back of another at
// the same entry and no forwarding is needed. Degenerate and off-screen
// triangles skip the walk. A finished result waits in the output register
// while the next beat is already taken.
module zbuffer_gouraud_triangle_raster_unit #(
  parameter int SCREEN_WIDTH  = zgr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = zgr_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [15:0] vert_x,
  input  logic signed [15:0] vert_y,
  input  logic [15:0]        vert_depth,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [15:0]        pixel_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        read_color,
  output logic [15:0]        read_depth,
  output logic [16:0]        drawn_count
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int XW     = $clog2(SCREEN_WIDTH);
  localparam int YW     = $clog2(SCREEN_HEIGHT);
  localparam int EW     = zgr_pkg::EDGE_W;
  localparam int NW     = zgr_pkg::NUM_W;
  localparam logic signed [13:0] XMAX = 14'(SCREEN_WIDTH - 1);
  localparam logic signed [13:0] YMAX = 14'(SCREEN_HEIGHT - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  zgr_pkg::state_t state, state_next;

  // Held vertices; entry two takes the vertex that completes a triangle.
  zgr_pkg::vertex_t vtx [3];
  zgr_pkg::vertex_t in_vtx;
  logic [1:0]       vcount;

  logic            fill_emit;
  logic [AW-1:0]   fill_addr;
  zgr_pkg::pixel_t fill_data;
  logic [AW-1:0]   read_addr;
  logic            read_in_range;

  logic [23:0] res_color;
  logic [15:0] res_depth;
  logic [16:0] count;

  // Screen-clamped bounding box and walk position.
  logic [XW-1:0] minx, maxx, px;
  logic [YW-1:0] miny, maxy, py;
  logic signed [13:0] box_minx, box_maxx, box_miny, box_maxy;
  logic               box_empty;

  // Edge setup multiply-accumulate.
  logic [1:0]               ej;
  logic                     eterm;
  zgr_pkg::vertex_t         eva, evb;
  logic signed [16:0]       emul_a;
  logic signed [17:0]       emul_b;
  logic signed [17:0]       cx0, cy0, ptx, pty;
  logic signed [34:0]       emul;
  logic signed [EW-1:0]     edge_prod;
  logic                     eprod_valid;
  logic [1:0]               eprod_j;
  logic                     eprod_term;
  logic signed [EW-1:0]     edge_acc [4];

  logic [EW-1:0]            aabs;
  logic signed [16:0]       ddx [3];
  logic signed [16:0]       ddy [3];
  logic signed [EW-1:0]     e_cur [3];
  logic signed [EW-1:0]     e_row [3];
  logic signed [EW-1:0]     edx [3];
  logic signed [EW-1:0]     edy [3];

  // Attribute setup multiply-accumulate.
  logic [1:0]               ak, aq, ai;
  logic signed [EW-1:0]     amul_e;
  zgr_pkg::vertex_t         amul_v;
  logic [15:0]              amul_attr;
  logic signed [52:0]       amul;
  logic signed [NW-1:0]     attr_prod;
  logic                     aprod_valid;
  logic [1:0]               aprod_k, aprod_q, aprod_i;
  logic signed [NW-1:0]     num [4][3];

  // Interpolation terms.
  logic [1:0]               dk, dq;
  logic                     div_start;
  zgr_pkg::div_res_t        div_res;
  zgr_pkg::acc_t            a_cur [4];
  zgr_pkg::acc_t            a_row [4];
  logic signed [NW-1:0]     dqx [4];
  logic signed [NW-1:0]     dqy [4];
  logic [EW-1:0]            drx [4];
  logic [EW-1:0]            dry [4];

  // Walk and write-back.
  logic            pix_hit;
  logic [AW-1:0]   pix_addr;
  zgr_pkg::pixel_t pix_new;
  logic            b_valid;
  logic [AW-1:0]   b_addr;
  zgr_pkg::pixel_t b_pix;
  logic            b_write;

  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  zgr_pkg::pixel_t mem_wr_data;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  zgr_pkg::pixel_t mem_rd_data;

  logic accept;
  logic emit_go;

  function automatic logic signed [13:0] floor16(logic signed [15:0] v);
    return 14'(v >>> 4);
  endfunction

  function automatic logic signed [13:0] ceil16(logic signed [15:0] v);
    logic signed [16:0] s;
    s = 17'(v) + 17'sd15;
    return 14'(s >>> 4);
  endfunction

  function automatic logic [15:0] attr_sel(zgr_pkg::vertex_t v, logic [1:0] k);
    logic [15:0] a;
    unique case (k)
      2'd0:    a = v.z;
      2'd1:    a = {8'h00, v.r};
      2'd2:    a = {8'h00, v.g};
      default: a = {8'h00, v.b};
    endcase
    return a;
  endfunction

  function automatic logic [7:0] clamp_color(logic signed [NW-1:0] q);
    return (|q[NW-1:8]) ? zgr_pkg::COLOR_MAX : q[7:0];
  endfunction

  assign accept  = in_valid && in_ready;
  assign emit_go = !out_valid || out_ready;
  assign in_vtx  = {vert_x, vert_y, vert_depth, red, green, blue};
  assign read_in_range = 32'(pixel_index) < 32'(PIXELS);

  // ---- Bounding box of the latched triangle ----
  always_comb begin
    logic signed [15:0] lox, hix, loy, hiy;
    lox = vtx[0].x; hix = vtx[0].x; loy = vtx[0].y; hiy = vtx[0].y;
    if (vtx[1].x < lox) lox = vtx[1].x;
    if (vtx[2].x < lox) lox = vtx[2].x;
    if (vtx[1].x > hix) hix = vtx[1].x;
    if (vtx[2].x > hix) hix = vtx[2].x;
    if (vtx[1].y < loy) loy = vtx[1].y;
    if (vtx[2].y < loy) loy = vtx[2].y;
    if (vtx[1].y > hiy) hiy = vtx[1].y;
    if (vtx[2].y > hiy) hiy = vtx[2].y;
    box_minx = floor16(lox);
    box_maxx = ceil16(hix);
    box_miny = floor16(loy);
    box_maxy = ceil16(hiy);
    if (box_minx < 14'sd0) box_minx = 14'sd0;
    if (box_maxx > XMAX)   box_maxx = XMAX;
    if (box_miny < 14'sd0) box_miny = 14'sd0;
    if (box_maxy > YMAX)   box_maxy = YMAX;
    box_empty = (box_minx > box_maxx) || (box_miny > box_maxy);
  end

  // ---- Edge setup operands ----
  // Edges zero and one run from vertex one to two and from two to zero;
  // edge two (from vertex zero to one) also gives the doubled area when it
  // is evaluated at vertex two.
  always_comb begin
    unique case (ej)
      2'd0:    begin eva = vtx[1]; evb = vtx[2]; end
      2'd1:    begin eva = vtx[2]; evb = vtx[0]; end
      default: begin eva = vtx[0]; evb = vtx[1]; end
    endcase
    cx0 = 18'({minx, 4'h8});
    cy0 = 18'({miny, 4'h8});
    ptx = (ej == 2'd3) ? 18'(vtx[2].x) : cx0;
    pty = (ej == 2'd3) ? 18'(vtx[2].y) : cy0;
    if (eterm) begin
      emul_a = 17'(evb.y) - 17'(eva.y);
      emul_b = ptx - 18'(eva.x);
    end else begin
      emul_a = 17'(evb.x) - 17'(eva.x);
      emul_b = pty - 18'(eva.y);
    end
    emul = emul_a * emul_b;
  end

  // Per-edge coordinate deltas for the walk steps.
  always_comb begin
    ddx[0] = 17'(vtx[2].x) - 17'(vtx[1].x);
    ddy[0] = 17'(vtx[2].y) - 17'(vtx[1].y);
    ddx[1] = 17'(vtx[0].x) - 17'(vtx[2].x);
    ddy[1] = 17'(vtx[0].y) - 17'(vtx[2].y);
    ddx[2] = 17'(vtx[1].x) - 17'(vtx[0].x);
    ddy[2] = 17'(vtx[1].y) - 17'(vtx[0].y);
  end

  // ---- Attribute setup operands ----
  always_comb begin
    unique case (aq)
      2'd0:    amul_e = e_row[ai];
      2'd1:    amul_e = edx[ai];
      default: amul_e = edy[ai];
    endcase
    unique case (ai)
      2'd0:    amul_v = vtx[0];
      2'd1:    amul_v = vtx[1];
      default: amul_v = vtx[2];
    endcase
    amul_attr = attr_sel(amul_v, ak);
    amul      = amul_e * signed'({1'b0, amul_attr});
  end

  // ---- Current pixel ----
  always_comb begin
    pix_hit  = !e_cur[0][EW-1] && !e_cur[1][EW-1] && !e_cur[2][EW-1];
    pix_addr = AW'(32'(py) * SCREEN_WIDTH + 32'(px));
    pix_new.depth = (|a_cur[0].q[NW-1:16]) ? zgr_pkg::FAR_DEPTH : a_cur[0].q[15:0];
    pix_new.color = {clamp_color(a_cur[1].q), clamp_color(a_cur[2].q),
                     clamp_color(a_cur[3].q)};
  end

  // The depth test uses the stored pixel read in the previous cycle.
  assign b_write = b_valid && (b_pix.depth < mem_rd_data.depth);

  // ---- Next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      zgr_pkg::ST_FILL: begin
        if (fill_addr == LAST_ADDR) begin
          state_next = fill_emit ? zgr_pkg::ST_EMIT : zgr_pkg::ST_IDLE;
        end
      end
      zgr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (zgr_pkg::kind_t'(kind))
            zgr_pkg::KIND_VERTEX: begin
              state_next = (vcount == 2'd2) ? zgr_pkg::ST_BOX : zgr_pkg::ST_EMIT;
            end
            zgr_pkg::KIND_CLEAR: state_next = zgr_pkg::ST_FILL;
            zgr_pkg::KIND_READ: begin
              state_next = read_in_range ? zgr_pkg::ST_READ : zgr_pkg::ST_EMIT;
            end
            default: state_next = zgr_pkg::ST_EMIT;
          endcase
        end
      end
      zgr_pkg::ST_READ:      state_next = zgr_pkg::ST_READ_DATA;
      zgr_pkg::ST_READ_DATA: state_next = zgr_pkg::ST_EMIT;
      zgr_pkg::ST_BOX: begin
        state_next = box_empty ? zgr_pkg::ST_EMIT : zgr_pkg::ST_EDGE;
      end
      zgr_pkg::ST_EDGE: begin
        if (eterm && (ej == 2'd3)) state_next = zgr_pkg::ST_EDGE_DRAIN;
      end
      zgr_pkg::ST_EDGE_DRAIN: state_next = zgr_pkg::ST_NORM;
      zgr_pkg::ST_NORM: begin
        state_next = (edge_acc[3] == '0) ? zgr_pkg::ST_EMIT : zgr_pkg::ST_ATTR;
      end
      zgr_pkg::ST_ATTR: begin
        if ((ak == 2'd3) && (aq == 2'd2) && (ai == 2'd2)) begin
          state_next = zgr_pkg::ST_ATTR_DRAIN;
        end
      end
      zgr_pkg::ST_ATTR_DRAIN: state_next = zgr_pkg::ST_DIV_START;
      zgr_pkg::ST_DIV_START:  state_next = zgr_pkg::ST_DIV_WAIT;
      zgr_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_next = ((dk == 2'd3) && (dq == 2'd2)) ? zgr_pkg::ST_WALK
                                                      : zgr_pkg::ST_DIV_START;
        end
      end
      zgr_pkg::ST_WALK: begin
        if ((px == maxx) && (py == maxy)) state_next = zgr_pkg::ST_DRAIN;
      end
      zgr_pkg::ST_DRAIN: state_next = zgr_pkg::ST_EMIT;
      zgr_pkg::ST_EMIT: begin
        if (emit_go) state_next = zgr_pkg::ST_IDLE;
      end
      default: state_next = zgr_pkg::ST_IDLE;
    endcase
  end

  // ---- State outputs ----
  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = pix_addr;
    mem_wr_en   = b_write;
    mem_wr_addr = b_addr;
    mem_wr_data = b_pix;
    unique case (state)
      zgr_pkg::ST_IDLE:      in_ready = 1'b1;
      zgr_pkg::ST_DIV_START: div_start = 1'b1;
      zgr_pkg::ST_READ: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = read_addr;
      end
      zgr_pkg::ST_WALK: mem_rd_en = pix_hit;
      zgr_pkg::ST_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_addr;
        mem_wr_data = fill_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zgr_pkg::ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // ---- Datapath ----
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount      <= 2'd0;
      fill_addr   <= '0;
      fill_data   <= '0;
      fill_emit   <= 1'b0;
      out_valid   <= 1'b0;
      b_valid     <= 1'b0;
      eprod_valid <= 1'b0;
      aprod_valid <= 1'b0;
      count       <= '0;
    end else begin
      b_valid     <= (state == zgr_pkg::ST_WALK) && pix_hit;
      b_addr      <= pix_addr;
      b_pix       <= pix_new;
      eprod_valid <= (state == zgr_pkg::ST_EDGE);
      edge_prod   <= EW'(emul);
      eprod_j     <= ej;
      eprod_term  <= eterm;
      aprod_valid <= (state == zgr_pkg::ST_ATTR);
      attr_prod   <= NW'(amul);
      aprod_k     <= ak;
      aprod_q     <= aq;
      aprod_i     <= ai;

      if (b_write) count <= count + 17'd1;

      if (eprod_valid) begin
        edge_acc[eprod_j] <= eprod_term ? edge_acc[eprod_j] - edge_prod : edge_prod;
      end
      if (aprod_valid) begin
        num[aprod_k][aprod_q] <= (aprod_i == 2'd0) ? attr_prod
                                                   : num[aprod_k][aprod_q] + attr_prod;
      end

      // A result is loaded when the output register is free or being taken.
      if ((state == zgr_pkg::ST_EMIT) && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        zgr_pkg::ST_FILL: fill_addr <= fill_addr + AW'(1);

        zgr_pkg::ST_IDLE: begin
          if (accept) begin
            count     <= '0;
            res_color <= '0;
            res_depth <= '0;
            fill_emit <= 1'b1;
            fill_addr <= '0;
            fill_data <= '{color: {red, green, blue}, depth: zgr_pkg::FAR_DEPTH};
            read_addr <= AW'(pixel_index);
            if (zgr_pkg::kind_t'(kind) == zgr_pkg::KIND_VERTEX) begin
              if (vcount == 2'd2) begin
                vtx[2] <= in_vtx;
                vcount <= 2'd0;
              end else begin
                vtx[vcount] <= in_vtx;
                vcount      <= vcount + 2'd1;
              end
            end
          end
        end

        zgr_pkg::ST_READ_DATA: begin
          res_color <= mem_rd_data.color;
          res_depth <= mem_rd_data.depth;
        end

        zgr_pkg::ST_BOX: begin
          minx  <= XW'(box_minx);
          maxx  <= XW'(box_maxx);
          miny  <= YW'(box_miny);
          maxy  <= YW'(box_maxy);
          ej    <= 2'd0;
          eterm <= 1'b0;
        end

        zgr_pkg::ST_EDGE: begin
          eterm <= !eterm;
          if (eterm) ej <= ej + 2'd1;
        end

        zgr_pkg::ST_NORM: begin
          // Orient all edges so that the inside is non-negative.
          aabs    <= edge_acc[3][EW-1] ? EW'(-edge_acc[3]) : EW'(edge_acc[3]);
          for (int i = 0; i < 3; i++) begin
            if (edge_acc[3][EW-1]) begin
              e_row[i] <= -edge_acc[i];
              e_cur[i] <= -edge_acc[i];
              edx[i]   <= EW'(ddy[i]) <<< 4;
              edy[i]   <= -(EW'(ddx[i]) <<< 4);
            end else begin
              e_row[i] <= edge_acc[i];
              e_cur[i] <= edge_acc[i];
              edx[i]   <= -(EW'(ddy[i]) <<< 4);
              edy[i]   <= EW'(ddx[i]) <<< 4;
            end
          end
          px <= minx;
          py <= miny;
          ak <= 2'd0;
          aq <= 2'd0;
          ai <= 2'd0;
        end

        zgr_pkg::ST_ATTR: begin
          if (ai == 2'd2) begin
            ai <= 2'd0;
            if (aq == 2'd2) begin
              aq <= 2'd0;
              ak <= ak + 2'd1;
            end else begin
              aq <= aq + 2'd1;
            end
          end else begin
            ai <= ai + 2'd1;
          end
          dk <= 2'd0;
          dq <= 2'd0;
        end

        zgr_pkg::ST_DIV_WAIT: begin
          if (div_res.done) begin
            unique case (dq)
              2'd0: begin
                a_cur[dk] <= '{q: div_res.quot, r: div_res.rem};
                a_row[dk] <= '{q: div_res.quot, r: div_res.rem};
              end
              2'd1: begin
                dqx[dk] <= div_res.quot;
                drx[dk] <= div_res.rem;
              end
              default: begin
                dqy[dk] <= div_res.quot;
                dry[dk] <= div_res.rem;
              end
            endcase
            if (dq == 2'd2) begin
              dq <= 2'd0;
              dk <= dk + 2'd1;
            end else begin
              dq <= dq + 2'd1;
            end
          end
        end

        zgr_pkg::ST_WALK: begin
          if (px == maxx) begin
            px <= minx;
            py <= py + YW'(1);
            for (int i = 0; i < 3; i++) begin
              e_row[i] <= e_row[i] + edy[i];
              e_cur[i] <= e_row[i] + edy[i];
            end
            for (int k = 0; k < 4; k++) begin
              a_row[k] <= zgr_pkg::acc_step(a_row[k], dqy[k], dry[k], aabs);
              a_cur[k] <= zgr_pkg::acc_step(a_row[k], dqy[k], dry[k], aabs);
            end
          end else begin
            px <= px + XW'(1);
            for (int i = 0; i < 3; i++) begin
              e_cur[i] <= e_cur[i] + edx[i];
            end
            for (int k = 0; k < 4; k++) begin
              a_cur[k] <= zgr_pkg::acc_step(a_cur[k], dqx[k], drx[k], aabs);
            end
          end
        end

        zgr_pkg::ST_EMIT: begin
          if (emit_go) begin
            read_color  <= res_color;
            read_depth  <= res_depth;
            drawn_count <= count;
          end
        end

        default: ;
      endcase
    end
  end

  zgr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (num[dk][dq]),
    .denom (aabs),
    .res   (div_res)
  );

  zgr_frame_mem #(
    .DEPTH (PIXELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

### rtl/zgr_checker.sv
// ----------------------------------------------------------------------------
// zgr_checker
// Port-level checks for the triangle rasterizer, bound to its top level.
// ----------------------------------------------------------------------------
module zgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] read_color,
  input logic [15:0] read_depth,
  input logic [16:0] drawn_count
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_color)
      && $stable(read_depth) && $stable(drawn_count))
    else $error("stalled result changed");

  // Every beat takes the block out of its idle state, so no beat follows back to back.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken back to back");

  // A triangle result never carries read data.
  a_fields_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid && (drawn_count != 17'd0) |-> (read_color == 24'd0)
      && (read_depth == 16'd0))
    else $error("triangle result carries pixel data");

endmodule

bind zbuffer_gouraud_triangle_raster_unit zgr_checker u_zgr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_color  (read_color),
  .read_depth  (read_depth),
  .drawn_count (drawn_count)
);

### bench/zbuffer_gouraud_triangle_raster_unit_test.sv
// ----------------------------------------------------------------------------
// zbuffer_gouraud_triangle_raster_unit_test
// Self-checking bench for the depth-buffered Gouraud triangle rasterizer.
// Vertex, clear, read and unused beats are sent from a queue through a
// randomly idling driver. A predictor keeps its own pixel store and held
// vertices and computes the expected result of every accepted beat. A
// monitor with a randomly stalling ready checks each result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module zbuffer_gouraud_triangle_raster_unit_test;

  localparam int SCR_W  = zgr_pkg::DEF_SCREEN_WIDTH;
  localparam int SCR_H  = zgr_pkg::DEF_SCREEN_HEIGHT;
  localparam int PIXELS = SCR_W * SCR_H;

  // One input beat as the driver presents it.
  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [15:0]        pix;
  } beat_t;

  // One result beat.
  typedef struct {
    logic [23:0] color;
    logic [15:0] depth;
    logic [16:0] count;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind = zgr_pkg::KIND_NONE;
  logic signed [15:0] vert_x = '0;
  logic signed [15:0] vert_y = '0;
  logic [15:0]        vert_depth = '0;
  logic [7:0]         red = '0;
  logic [7:0]         green = '0;
  logic [7:0]         blue = '0;
  logic [15:0]        pixel_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [23:0]        read_color;
  logic [15:0]        read_depth;
  logic [16:0]        drawn_count;

  always #2 clk = ~clk;

  zbuffer_gouraud_triangle_raster_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .vert_x(vert_x), .vert_y(vert_y), .vert_depth(vert_depth),
    .red(red), .green(green), .blue(blue), .pixel_index(pixel_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_color(read_color), .read_depth(read_depth), .drawn_count(drawn_count)
  );

  // Beats waiting to be sent and results waiting to arrive.
  beat_t   send_queue[$];
  result_t expected_results[$];

  // Idle and stall percentages of the current phase.
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int triangles_seen = 0;
  int pixels_drawn = 0;
  int reads_seen = 0;
  int clears_seen = 0;

  // The predictor's own copy of the pixel store and held vertices.
  logic [23:0]      shadow_color [PIXELS];
  logic [15:0]      shadow_depth [PIXELS];
  zgr_pkg::vertex_t held_vtx [2];
  int               held_count = 0;

  initial begin
    for (int i = 0; i < PIXELS; i++) begin
      shadow_color[i] = '0;
      shadow_depth[i] = '0;
    end
    held_vtx[0] = '0;
    held_vtx[1] = '0;
  end

  // Doubled signed area of (a, b, c): positive when c is left of a->b.
  function automatic longint edge_fn(zgr_pkg::vertex_t a, zgr_pkg::vertex_t b,
                                     longint cx, longint cy);
    return (longint'(b.x) - longint'(a.x)) * (cy - longint'(a.y)) -
           (longint'(b.y) - longint'(a.y)) * (cx - longint'(a.x));
  endfunction

  function automatic longint unsigned blend(longint e0, longint e1, longint e2,
                                            longint a0, longint a1, longint a2,
                                            longint unsigned area);
    return longint'(e0 * a0 + e1 * a1 + e2 * a2) / area;
  endfunction

  // Draws one triangle into the shadow store and returns the pixels written.
  function automatic int draw_triangle(zgr_pkg::vertex_t v0, zgr_pkg::vertex_t v1,
                                       zgr_pkg::vertex_t v2);
    longint area, sgn, lo, hi, minx, maxx, miny, maxy, cx, cy, e0, e1, e2;
    longint unsigned aabs, z, r, g, b;
    int idx, written;
    written = 0;
    area = edge_fn(v0, v1, v2.x, v2.y);
    if (area == 0) return 0;
    sgn = (area < 0) ? -1 : 1;
    aabs = area * sgn;
    lo = v0.x; hi = v0.x;
    if (v1.x < lo) lo = v1.x;
    if (v2.x < lo) lo = v2.x;
    if (v1.x > hi) hi = v1.x;
    if (v2.x > hi) hi = v2.x;
    minx = lo >>> 4;
    maxx = -((-hi) >>> 4);
    lo = v0.y; hi = v0.y;
    if (v1.y < lo) lo = v1.y;
    if (v2.y < lo) lo = v2.y;
    if (v1.y > hi) hi = v1.y;
    if (v2.y > hi) hi = v2.y;
    miny = lo >>> 4;
    maxy = -((-hi) >>> 4);
    if (minx < 0) minx = 0;
    if (maxx > SCR_W - 1) maxx = SCR_W - 1;
    if (miny < 0) miny = 0;
    if (maxy > SCR_H - 1) maxy = SCR_H - 1;
    for (longint py = miny; py <= maxy; py++) begin
      cy = py * 16 + 8;
      for (longint px = minx; px <= maxx; px++) begin
        cx = px * 16 + 8;
        e0 = edge_fn(v1, v2, cx, cy) * sgn;
        e1 = edge_fn(v2, v0, cx, cy) * sgn;
        e2 = edge_fn(v0, v1, cx, cy) * sgn;
        if (e0 < 0 || e1 < 0 || e2 < 0) continue;
        idx = int'(py * SCR_W + px);
        z = blend(e0, e1, e2, v0.z, v1.z, v2.z, aabs);
        if (z > zgr_pkg::FAR_DEPTH) z = zgr_pkg::FAR_DEPTH;
        if (!(z < shadow_depth[idx])) continue;
        r = blend(e0, e1, e2, v0.r, v1.r, v2.r, aabs);
        g = blend(e0, e1, e2, v0.g, v1.g, v2.g, aabs);
        b = blend(e0, e1, e2, v0.b, v1.b, v2.b, aabs);
        if (r > zgr_pkg::COLOR_MAX) r = zgr_pkg::COLOR_MAX;
        if (g > zgr_pkg::COLOR_MAX) g = zgr_pkg::COLOR_MAX;
        if (b > zgr_pkg::COLOR_MAX) b = zgr_pkg::COLOR_MAX;
        shadow_depth[idx] = z[15:0];
        shadow_color[idx] = {r[7:0], g[7:0], b[7:0]};
        written++;
      end
    end
    return written;
  endfunction

  // Applies one accepted beat to the shadow state and queues its result.
  task automatic predict_beat(beat_t it);
    result_t          res;
    zgr_pkg::vertex_t v;
    res = '{default: '0};
    v = '{x: it.x, y: it.y, z: it.z, r: it.r, g: it.g, b: it.b};
    case (it.kind)
      zgr_pkg::KIND_VERTEX: begin
        if (held_count < 2) begin
          held_vtx[held_count] = v;
          held_count++;
        end else begin
          held_count = 0;
          res.count = 17'(draw_triangle(held_vtx[0], held_vtx[1], v));
          triangles_seen++;
          pixels_drawn += res.count;
        end
      end
      zgr_pkg::KIND_CLEAR: begin
        for (int i = 0; i < PIXELS; i++) begin
          shadow_color[i] = {it.r, it.g, it.b};
          shadow_depth[i] = zgr_pkg::FAR_DEPTH;
        end
        clears_seen++;
      end
      zgr_pkg::KIND_READ: begin
        res.color = shadow_color[it.pix];
        res.depth = shadow_depth[it.pix];
        reads_seen++;
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endtask

  // Driver: a new beat is only loaded when the line is free or was just taken.
  beat_t next_beat;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_beat(next_beat);
      if (!in_valid || in_ready) begin
        if (send_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_beat = send_queue.pop_front();
          in_valid    <= 1'b1;
          kind        <= next_beat.kind;
          vert_x      <= next_beat.x;
          vert_y      <= next_beat.y;
          vert_depth  <= next_beat.z;
          red         <= next_beat.r;
          green       <= next_beat.g;
          blue        <= next_beat.b;
          pixel_index <= next_beat.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result beat against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: color %h depth %h count %0d",
                   $time, read_color, read_depth, drawn_count);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (read_color !== want.color) begin
            $display("%0t: read_color expected %h actual %h", $time, want.color, read_color);
            error_count++;
          end
          if (read_depth !== want.depth) begin
            $display("%0t: read_depth expected %h actual %h", $time, want.depth, read_depth);
            error_count++;
          end
          if (drawn_count !== want.count) begin
            $display("%0t: drawn_count expected %0d actual %0d", $time, want.count,
                     drawn_count);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Stimulus helpers.
  task automatic push_beat(logic [1:0] k, int x, int y, int z, int r, int g, int b,
                           int pix);
    send_queue.push_back('{kind: k, x: 16'(x), y: 16'(y), z: 16'(z), r: 8'(r),
                           g: 8'(g), b: 8'(b), pix: 16'(pix)});
  endtask

  task automatic push_vertex(int x, int y, int z, int r, int g, int b);
    push_beat(zgr_pkg::KIND_VERTEX, x, y, z, r, g, b, $urandom);
  endtask

  task automatic push_read(int pix);
    push_beat(zgr_pkg::KIND_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, pix);
  endtask

  task automatic push_clear();
    push_beat(zgr_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endtask

  // Small triangles stay near a center so the walk stays short.
  int center_x = 128;
  int center_y = 128;

  task automatic push_near_vertex();
    push_vertex(center_x * 16 + $urandom_range(0, 640) - 320,
                center_y * 16 + $urandom_range(0, 640) - 320,
                $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_near_read();
    push_read(((center_y + $urandom_range(0, 40) - 20) & 255) * SCR_W +
              ((center_x + $urandom_range(0, 40) - 20) & 255));
  endtask

  task automatic wait_drained();
    while (send_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int beats, int idle_pct, int stall_pct);
    int sent, pick;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    push_clear();
    // One triangle with full-range corners: clamped, it covers much of the screen.
    push_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    sent = 4;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        center_x = $urandom_range(0, 255);
        center_y = $urandom_range(0, 255);
        repeat (3) push_near_vertex();
        push_near_read();
        push_near_read();
        sent += 5;
      end else if (pick < 70) begin
        // A triangle broken up by reads and unused beats.
        center_x = $urandom_range(0, 255);
        center_y = $urandom_range(0, 255);
        push_near_vertex();
        push_near_read();
        push_near_vertex();
        push_beat(zgr_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        push_near_vertex();
        push_near_read();
        sent += 6;
      end else if (pick < 85) begin
        push_read($urandom);
        sent++;
      end else if (pick < 92) begin
        push_beat(zgr_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        sent++;
      end else begin
        // Wholly off screen, high or negative: skipped without a walk.
        if ($urandom_range(0, 1)) begin
          repeat (3) push_vertex($urandom_range(4200, 32767), $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
        end else begin
          repeat (3) push_vertex($urandom, -$urandom_range(32, 32768), $urandom,
                                 $urandom, $urandom, $urandom);
        end
        sent += 3;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Fresh store: reads give zero, a triangle draws nothing.
    push_read(0);
    push_vertex(160, 160, 100, 10, 20, 30);
    push_vertex(800, 160, 100, 10, 20, 30);
    push_vertex(160, 800, 100, 10, 20, 30);
    push_clear();
    push_beat(zgr_pkg::KIND_CLEAR, 0, 0, 0, 255, 255, 255, 0);
    push_read(65535);
    // Held vertices survive a clear in the middle of a triangle.
    push_vertex(0, 0, 0, 255, 0, 0);
    push_beat(zgr_pkg::KIND_CLEAR, 0, 0, 0, 1, 2, 3, 0);
    push_vertex(1600, 0, 65535, 0, 255, 0);
    push_vertex(0, 1600, 32768, 0, 0, 255);
    push_read(5 * SCR_W + 5);
    // Same triangle again: equal depth does not draw.
    push_vertex(0, 0, 0, 255, 0, 0);
    push_vertex(1600, 0, 65535, 0, 255, 0);
    push_vertex(0, 1600, 32768, 0, 0, 255);
    // Zero area, then wholly off screen at the coordinate extremes.
    push_vertex(100, 100, 5, 1, 1, 1);
    push_vertex(200, 200, 5, 1, 1, 1);
    push_vertex(300, 300, 5, 1, 1, 1);
    push_vertex(32767, 32767, 0, 0, 0, 0);
    push_vertex(-32768, 32767, 0, 0, 0, 0);
    push_vertex(32767, 32767, 0, 0, 0, 0);
    // Larger than the screen: its box is clamped on every side, but no pixel centre lies inside it.
    push_vertex(-32768, -32768, 0, 255, 255, 255);
    push_vertex(32767, -32768, 0, 255, 255, 255);
    push_vertex(-32768, 32767, 0, 255, 255, 255);
    push_read(128 * SCR_W + 7);
    push_beat(zgr_pkg::KIND_NONE, -1, -1, 65535, 255, 255, 255, 65535);
    wait_drained();

    // Random part: no idling, sender idle, receiver stalls, then both.
    random_phase(145, 0, 0);
    random_phase(145, 59, 0);
    random_phase(145, 0, 59);
    random_phase(145, 19, 19);

    // Let any work in flight settle before the verdict.
    repeat (2000) @(posedge clk);
    $display("Covered %0d triangles drawing %0d pixels, %0d reads and %0d clears.",
             triangles_seen, pixels_drawn, reads_seen, clears_seen);
    $display("Mismatches found: %0d.", error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("** zbuffer_gouraud_triangle_raster_unit: PASSED **");
    end else begin
      $display("** zbuffer_gouraud_triangle_raster_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #80_000_000;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("** zbuffer_gouraud_triangle_raster_unit: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/zgr_pkg.sv
rtl/zgr_frame_mem.sv
rtl/zgr_div.sv
rtl/zbuffer_gouraud_triangle_raster_unit.sv
rtl/zgr_checker.sv
bench/zbuffer_gouraud_triangle_raster_unit_test.sv
